// File: rtl/chm_pkg.sv
`default_nettype none

package chm_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int OP_W  = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_GET    = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_HEAD,
      ST_WALK,
      ST_CHECK,
      ST_ACT,
      ST_POP,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

// File: rtl/chm_ram.sv
`default_nettype none

module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/chm_hash.sv
`default_nettype none

module chm_hash #(
   parameter int NUM_BUCKETS = 16,
   parameter int BW          = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic signed [chm_pkg::KEY_W-1:0] key,
   output logic                                done,
   output logic [BW-1:0]                       bucket
);

   localparam bit IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

   generate
      if (IS_POW2) begin : g_mask
         // The low bits of the two's complement key already give the
         // nonnegative remainder.
         logic          done_ff;
         logic [BW-1:0] bucket_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               bucket_ff <= BW'(key & chm_pkg::KEY_W'(NUM_BUCKETS - 1));
            end
         end

         assign done   = done_ff;
         assign bucket = bucket_ff;
      end else begin : g_divide
         // The key magnitude is reduced one byte at a time, most significant
         // byte first. For each byte the quotient digit is found first, by
         // multiplying with the scaled reciprocal of NUM_BUCKETS, and its multiple
         // is then subtracted from the partial remainder. Negative keys are folded
         // to the nonnegative remainder at the output.
         localparam int RW = $clog2(NUM_BUCKETS);
         localparam int TW = RW + 8;
         localparam int PW = TW + 32;
         localparam longint unsigned RECIP_L =
            ((64'd1 << 32) + longint'(NUM_BUCKETS) - 64'd1) / longint'(NUM_BUCKETS);
         localparam logic [31:0] RECIP = 32'(RECIP_L);

         logic [chm_pkg::KEY_W-1:0] mag_ff, mag_in;
         logic [RW-1:0]             rem_ff, rem_in;
         logic                      neg_ff, neg_in;
         logic [7:0]                quo_ff, quo_in;
         logic [3:0]                cnt_ff, cnt_in;
         logic                      done_ff, done_in;
         logic [TW-1:0]             part;
         logic [PW-1:0]             prod;
         logic [TW-1:0]             quo_mult;

         assign part     = {rem_ff, mag_ff[chm_pkg::KEY_W-1 -: 8]};
         assign prod     = PW'(part) * PW'(RECIP);
         assign quo_mult = TW'(quo_ff) * TW'(NUM_BUCKETS);

         always_comb begin
            mag_in  = mag_ff;
            rem_in  = rem_ff;
            neg_in  = neg_ff;
            quo_in  = quo_ff;
            cnt_in  = cnt_ff;
            done_in = 1'b0;
            if (start) begin
               mag_in = key[chm_pkg::KEY_W-1] ? (chm_pkg::KEY_W'(0) - key) : key;
               neg_in = key[chm_pkg::KEY_W-1];
               rem_in = '0;
               cnt_in = 4'd8;
            end else if (cnt_ff != 4'd0) begin
               if (!cnt_ff[0]) begin
                  quo_in = prod[32 +: 8];
               end else begin
                  rem_in = RW'(part - quo_mult);
                  mag_in = mag_ff << 8;
               end
               cnt_in  = cnt_ff - 4'd1;
               done_in = (cnt_ff == 4'd1);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               cnt_ff  <= 4'd0;
               done_ff <= 1'b0;
            end else begin
               cnt_ff  <= cnt_in;
               done_ff <= done_in;
            end
         end

         always_ff @(posedge clock) begin
            mag_ff <= mag_in;
            rem_ff <= rem_in;
            neg_ff <= neg_in;
            quo_ff <= quo_in;
         end

         assign done   = done_ff;
         assign bucket = (neg_ff && rem_ff != '0) ? BW'(RW'(NUM_BUCKETS) - rem_ff)
                                                 : BW'(rem_ff);
      end
   endgenerate

endmodule

`default_nettype wire

// File: rtl/chained_hash_map_core.sv
`default_nettype none

// Key-value map with separate chaining. Keys go to one of NUM_BUCKETS
// buckets by their nonnegative remainder; each bucket is a linked chain of
// entries from a pool of CAPACITY entries held in block memory, with bucket
// heads and a free-entry stack in two further memories. One request is
// worked at a time and returns exactly one response. A request passes the
// hash, the bucket head read, the chain walk (one entry memory read and one
// key compare for every chain entry visited), the action, a free-entry pop
// when an insert adds a new key, and the result, where it waits while the
// response register is held; a request with the unused code goes straight
// to the result. If NUM_BUCKETS is not a power of two the bucket remainder
// is found one byte at a time. After reset a clearing pass over
// max(NUM_BUCKETS, CAPACITY) addresses initializes the heads and the free
// stack before the first request is taken. A new request may be accepted
// while the previous response still waits in the output register.
module chained_hash_map_core #(
   parameter int NUM_BUCKETS = 16,
   parameter int CAPACITY    = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [chm_pkg::OP_W-1:0]          req_type,
   input  wire logic signed [chm_pkg::KEY_W-1:0]  req_key,
   input  wire logic signed [chm_pkg::VAL_W-1:0]  req_new_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [chm_pkg::VAL_W-1:0]       rsp_read_value,
   output logic                                   rsp_found,
   output logic                                   rsp_status
);

   localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW    = $clog2(CAPACITY + 1);
   localparam int EW    = chm_pkg::KEY_W + chm_pkg::VAL_W + LW;
   localparam int CLR_N = (NUM_BUCKETS > CAPACITY) ? NUM_BUCKETS : CAPACITY;
   localparam int CLRW  = $clog2(CLR_N + 1);
   localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

   chm_pkg::state_type state_ff, state_in;

   logic [CLRW-1:0]           clr_ff, clr_in;
   logic [LW-1:0]             fc_ff, fc_in;
   logic [chm_pkg::OP_W-1:0]  op_ff, op_in;
   logic [chm_pkg::KEY_W-1:0] key_ff, key_in;
   logic [chm_pkg::VAL_W-1:0] val_ff, val_in;
   logic [BW-1:0]             bucket_ff, bucket_in;
   logic [LW-1:0]             head_ff, head_in;
   logic [LW-1:0]             cur_ff, cur_in;
   logic [LW-1:0]             prev_ff, prev_in;
   logic [chm_pkg::KEY_W-1:0] prev_key_ff, prev_key_in;
   logic [chm_pkg::VAL_W-1:0] prev_data_ff, prev_data_in;
   logic [LW-1:0]             steps_ff, steps_in;
   logic                      hit_ff, hit_in;
   logic [LW-1:0]             hit_idx_ff, hit_idx_in;
   logic [chm_pkg::VAL_W-1:0] hit_data_ff, hit_data_in;
   logic [LW-1:0]             hit_link_ff, hit_link_in;
   logic [chm_pkg::VAL_W-1:0] res_value_ff, res_value_in;
   logic                      res_found_ff, res_found_in;
   logic                      res_status_ff, res_status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [chm_pkg::VAL_W-1:0] rsp_value_ff;
   logic                      rsp_found_ff, rsp_status_ff;
   logic                      rsp_load;

   logic                      hash_start, hash_done;
   logic [BW-1:0]             hash_bucket;

   logic                      head_we, head_re;
   logic [BW-1:0]             head_wa, head_ra;
   logic [LW-1:0]             head_wd, head_rd;

   logic                      ent_we, ent_re;
   logic [AW-1:0]             ent_wa, ent_ra;
   logic [EW-1:0]             ent_wd, ent_rd;
   logic [chm_pkg::KEY_W-1:0] ent_rd_key;
   logic [chm_pkg::VAL_W-1:0] ent_rd_data;
   logic [LW-1:0]             ent_rd_link;

   logic                      free_we, free_re;
   logic [AW-1:0]             free_wa, free_ra, free_wd, free_rd;
   logic [LW-1:0]             fc_dec;

   assign ent_rd_key  = ent_rd[EW-1 -: chm_pkg::KEY_W];
   assign ent_rd_data = ent_rd[LW + chm_pkg::VAL_W - 1 -: chm_pkg::VAL_W];
   assign ent_rd_link = ent_rd[LW-1:0];
   assign fc_dec      = fc_ff - LW'(1);

   chm_hash #(.NUM_BUCKETS(NUM_BUCKETS), .BW(BW)) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (req_key),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   chm_ram #(.WIDTH(LW), .DEPTH(NUM_BUCKETS), .AW(BW)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_wa),
      .wr_data (head_wd),
      .rd_en   (head_re),
      .rd_addr (head_ra),
      .rd_data (head_rd)
   );

   chm_ram #(.WIDTH(EW), .DEPTH(CAPACITY), .AW(AW)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_wa),
      .wr_data (ent_wd),
      .rd_en   (ent_re),
      .rd_addr (ent_ra),
      .rd_data (ent_rd)
   );

   chm_ram #(.WIDTH(AW), .DEPTH(CAPACITY), .AW(AW)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_we),
      .wr_addr (free_wa),
      .wr_data (free_wd),
      .rd_en   (free_re),
      .rd_addr (free_ra),
      .rd_data (free_rd)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      fc_in         = fc_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      bucket_in     = bucket_ff;
      head_in       = head_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_key_in   = prev_key_ff;
      prev_data_in  = prev_data_ff;
      steps_in      = steps_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_data_in   = hit_data_ff;
      hit_link_in   = hit_link_ff;
      res_value_in  = res_value_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_load      = 1'b0;
      hash_start    = 1'b0;
      head_we       = 1'b0;
      head_wa       = bucket_ff;
      head_wd       = NULL_LINK;
      head_re       = 1'b0;
      head_ra       = hash_bucket;
      ent_we        = 1'b0;
      ent_wa        = hit_idx_ff[AW-1:0];
      ent_wd        = {key_ff, val_ff, hit_link_ff};
      ent_re        = 1'b0;
      ent_ra        = cur_ff[AW-1:0];
      free_we       = 1'b0;
      free_wa       = fc_ff[AW-1:0];
      free_wd       = hit_idx_ff[AW-1:0];
      free_re       = 1'b0;
      free_ra       = fc_dec[AW-1:0];

      case (state_ff)
         chm_pkg::ST_CLEAR: begin
            if (clr_ff < CLRW'(NUM_BUCKETS)) begin
               head_we = 1'b1;
               head_wa = clr_ff[BW-1:0];
               head_wd = NULL_LINK;
            end
            if (clr_ff < CLRW'(CAPACITY)) begin
               free_we = 1'b1;
               free_wa = clr_ff[AW-1:0];
               free_wd = clr_ff[AW-1:0];
            end
            clr_in = clr_ff + CLRW'(1);
            if (clr_ff == CLRW'(CLR_N - 1)) begin
               state_in = chm_pkg::ST_IDLE;
            end
         end
         chm_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in         = req_type;
               key_in        = req_key;
               val_in        = req_new_value;
               res_value_in  = chm_pkg::MISS_VALUE;
               res_found_in  = 1'b0;
               res_status_in = chm_pkg::STATUS_OK;
               if (req_type inside {chm_pkg::OP_INSERT, chm_pkg::OP_GET,
                                    chm_pkg::OP_REMOVE}) begin
                  hash_start = 1'b1;
                  state_in   = chm_pkg::ST_HASH;
               end else begin
                  state_in = chm_pkg::ST_RESULT;
               end
            end
         end
         chm_pkg::ST_HASH: begin
            if (hash_done) begin
               bucket_in = hash_bucket;
               head_re   = 1'b1;
               head_ra   = hash_bucket;
               state_in  = chm_pkg::ST_HEAD;
            end
         end
         chm_pkg::ST_HEAD: begin
            head_in  = head_rd;
            cur_in   = head_rd;
            prev_in  = NULL_LINK;
            steps_in = '0;
            hit_in   = 1'b0;
            state_in = chm_pkg::ST_WALK;
         end
         chm_pkg::ST_WALK: begin
            if (cur_ff >= NULL_LINK || steps_ff == LW'(CAPACITY)) begin
               state_in = chm_pkg::ST_ACT;
            end else begin
               ent_re   = 1'b1;
               ent_ra   = cur_ff[AW-1:0];
               state_in = chm_pkg::ST_CHECK;
            end
         end
         chm_pkg::ST_CHECK: begin
            if (ent_rd_key == key_ff) begin
               hit_in      = 1'b1;
               hit_idx_in  = cur_ff;
               hit_data_in = ent_rd_data;
               hit_link_in = ent_rd_link;
               state_in    = chm_pkg::ST_ACT;
            end else begin
               prev_in      = cur_ff;
               prev_key_in  = ent_rd_key;
               prev_data_in = ent_rd_data;
               cur_in       = ent_rd_link;
               steps_in     = steps_ff + LW'(1);
               state_in     = chm_pkg::ST_WALK;
            end
         end
         chm_pkg::ST_ACT: begin
            state_in     = chm_pkg::ST_RESULT;
            res_found_in = hit_ff;
            case (op_ff)
               chm_pkg::OP_INSERT: begin
                  if (hit_ff) begin
                     ent_we = 1'b1;
                     ent_wa = hit_idx_ff[AW-1:0];
                     ent_wd = {key_ff, val_ff, hit_link_ff};
                  end else if (fc_ff == '0) begin
                     res_status_in = chm_pkg::STATUS_FULL;
                  end else begin
                     free_re  = 1'b1;
                     free_ra  = fc_dec[AW-1:0];
                     fc_in    = fc_dec;
                     state_in = chm_pkg::ST_POP;
                  end
               end
               chm_pkg::OP_GET: begin
                  if (hit_ff) begin
                     res_value_in = hit_data_ff;
                  end
               end
               chm_pkg::OP_REMOVE: begin
                  if (hit_ff) begin
                     if (prev_ff >= NULL_LINK) begin
                        head_we = 1'b1;
                        head_wa = bucket_ff;
                        head_wd = hit_link_ff;
                     end else begin
                        ent_we = 1'b1;
                        ent_wa = prev_ff[AW-1:0];
                        ent_wd = {prev_key_ff, prev_data_ff, hit_link_ff};
                     end
                     if (fc_ff < LW'(CAPACITY)) begin
                        free_we = 1'b1;
                        free_wa = fc_ff[AW-1:0];
                        free_wd = hit_idx_ff[AW-1:0];
                        fc_in   = fc_ff + LW'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         chm_pkg::ST_POP: begin
            // The popped entry becomes the new head of the chain.
            ent_we   = 1'b1;
            ent_wa   = free_rd;
            ent_wd   = {key_ff, val_ff, head_ff};
            head_we  = 1'b1;
            head_wa  = bucket_ff;
            head_wd  = LW'(free_rd);
            state_in = chm_pkg::ST_RESULT;
         end
         chm_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = chm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = chm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chm_pkg::ST_CLEAR;
         clr_ff       <= '0;
         fc_ff        <= LW'(CAPACITY);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fc_ff        <= fc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      bucket_ff     <= bucket_in;
      head_ff       <= head_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_key_ff   <= prev_key_in;
      prev_data_ff  <= prev_data_in;
      steps_ff      <= steps_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_data_ff   <= hit_data_in;
      hit_link_ff   <= hit_link_in;
      res_value_ff  <= res_value_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_value_ff  <= res_value_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign req_stall      = (state_ff != chm_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

// File: rtl/chm_checker.sv
`default_nettype none

module chm_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [chm_pkg::VAL_W-1:0]   rsp_read_value,
   input wire logic                        rsp_found,
   input wire logic                        rsp_status
);

   logic [1:0] pend_ff, pend_in;
   logic       in_xfer, out_xfer;

   assign in_xfer  = req_valid && !req_stall;
   assign out_xfer = rsp_valid && !rsp_stall;

   always_comb begin
      pend_in = pend_ff;
      if (in_xfer && !out_xfer) begin
         pend_in = pend_ff + 2'd1;
      end else if (!in_xfer && out_xfer) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Every response transfer answers a request that was taken earlier.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      out_xfer |-> pend_ff != 2'd0)
      else $error("response without an outstanding request");

   // At most one request in work and one response waiting.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many outstanding requests");

   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_read_value == chm_pkg::MISS_VALUE)
      else $error("miss response carries a value");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_found)
      else $error("dropped insert reports a found key");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value))
      else $error("stalled response changed");

endmodule

bind chained_hash_map_core chm_checker u_chm_checker (.*);

`default_nettype wire

// File: tb/chained_hash_map_checker.sv
`timescale 1ns / 1ps

module chained_hash_map_checker #(
   parameter int NUM_BUCKETS = 16,
   parameter int CAPACITY    = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire logic [chm_pkg::OP_W-1:0]         req_type,
   input  wire logic signed [chm_pkg::KEY_W-1:0] req_key,
   input  wire logic signed [chm_pkg::VAL_W-1:0] req_new_value,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire logic signed [chm_pkg::VAL_W-1:0] rsp_read_value,
   input  wire logic                             rsp_found,
   input  wire logic                             rsp_status,
   output int                                    fail_count,
   output int                                    pending_count
);

   typedef struct packed {
      logic [chm_pkg::VAL_W-1:0] read_value;
      logic                      found;
      logic                      status;
   } answer_type;

   localparam int NULL_IDX = CAPACITY;

   int                        head_idx  [NUM_BUCKETS];
   logic [chm_pkg::KEY_W-1:0] slot_key  [CAPACITY];
   logic [chm_pkg::VAL_W-1:0] slot_val  [CAPACITY];
   int                        slot_next [CAPACITY];
   int                        free_idx  [CAPACITY];
   int                        free_left;
   answer_type                answer_queue [$];

   function automatic int bucket_index(logic signed [chm_pkg::KEY_W-1:0] k);
      int r;
      begin
         r = k % NUM_BUCKETS;
         if (r < 0) r += NUM_BUCKETS;
         return r;
      end
   endfunction

   // Applies one request to the shadow map and returns its answer.
   function automatic answer_type apply_request(logic [chm_pkg::OP_W-1:0] op,
                                                logic signed [chm_pkg::KEY_W-1:0] k,
                                                logic [chm_pkg::VAL_W-1:0] v);
      answer_type a;
      int b, cur, prev, hit, steps, e;
      begin
         a.read_value = chm_pkg::MISS_VALUE;
         a.found = 1'b0;
         a.status = chm_pkg::STATUS_OK;
         if (op != chm_pkg::OP_INSERT && op != chm_pkg::OP_GET &&
             op != chm_pkg::OP_REMOVE) return a;
         b = bucket_index(k);
         cur = head_idx[b];
         prev = NULL_IDX;
         hit = NULL_IDX;
         steps = 0;
         while (cur < NULL_IDX && steps < CAPACITY && hit == NULL_IDX) begin
            if (slot_key[cur] == k) hit = cur;
            else begin
               prev = cur;
               cur = slot_next[cur];
            end
            steps++;
         end
         a.found = (hit != NULL_IDX);
         if (op == chm_pkg::OP_INSERT) begin
            if (a.found) slot_val[hit] = v;
            else if (free_left == 0) a.status = chm_pkg::STATUS_FULL;
            else begin
               free_left--;
               e = free_idx[free_left];
               slot_key[e] = k;
               slot_val[e] = v;
               slot_next[e] = head_idx[b];
               head_idx[b] = e;
            end
         end else if (op == chm_pkg::OP_GET) begin
            if (a.found) a.read_value = slot_val[hit];
         end else if (a.found) begin
            if (prev != NULL_IDX) slot_next[prev] = slot_next[hit];
            else head_idx[b] = slot_next[hit];
            free_idx[free_left] = hit;
            free_left++;
         end
         return a;
      end
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [chm_pkg::VAL_W-1:0] got,
                                  input logic [chm_pkg::VAL_W-1:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      answer_type w;
      if (reset) begin
         for (int i = 0; i < NUM_BUCKETS; i++) head_idx[i] = NULL_IDX;
         for (int i = 0; i < CAPACITY; i++) begin
            free_idx[i] = i;
            slot_next[i] = NULL_IDX;
            slot_key[i] = '0;
            slot_val[i] = '0;
         end
         free_left = CAPACITY;
         answer_queue.delete();
         fail_count = 0;
         pending_count = 0;
      end else begin
         // The response is checked before the request of the same edge is
         // applied, since a response always belongs to an earlier transfer.
         if (rsp_valid && !rsp_stall) begin
            if (answer_queue.size() == 0) begin
               report_mismatch("unexpected response", rsp_read_value, '0);
            end else begin
               w = answer_queue.pop_front();
               if (rsp_read_value !== w.read_value)
                  report_mismatch("read_value", rsp_read_value, w.read_value);
               if (rsp_found !== w.found)
                  report_mismatch("found", chm_pkg::VAL_W'(rsp_found),
                                  chm_pkg::VAL_W'(w.found));
               if (rsp_status !== w.status)
                  report_mismatch("status", chm_pkg::VAL_W'(rsp_status),
                                  chm_pkg::VAL_W'(w.status));
            end
         end
         if (req_valid && !req_stall)
            answer_queue.push_back(apply_request(req_type, req_key, req_new_value));
         pending_count = answer_queue.size();
      end
   end

endmodule

`default_nettype wire

// File: tb/chained_hash_map_core_tb.sv
`timescale 1ns / 1ps

module chained_hash_map_core_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [chm_pkg::OP_W-1:0] req_type = chm_pkg::OP_GET;
   logic signed [chm_pkg::KEY_W-1:0] req_key = '0;
   logic signed [chm_pkg::VAL_W-1:0] req_new_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [chm_pkg::VAL_W-1:0] rsp_read_value;
   logic rsp_found;
   logic rsp_status;
   int fail_count;
   int pending_count;
   int req_sent = 0;
   bit quiet_phase = 1'b0;
   bit hold_rsp = 1'b0;

   chained_hash_map_core uut (.*);

   chained_hash_map_checker checker_i (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Keys are mostly drawn from a small set so chains grow, hit and empty out.
   function automatic logic [chm_pkg::KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'sh8000_0000 + $urandom_range(0, 40);
         2: return 32'sh7FFF_FFFF - $urandom_range(0, 40);
         default: return $signed($urandom_range(0, 95)) - 48;
      endcase
   endfunction

   // Valid stays high from one transfer to the next unless an idle cycle
   // is drawn, so back-to-back requests need no extra edge.
   task automatic send_request(input logic [chm_pkg::OP_W-1:0] op,
                               input logic [chm_pkg::KEY_W-1:0] k,
                               input logic [chm_pkg::VAL_W-1:0] v, input bit gaps);
      while (gaps && !quiet_phase && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_key <= k;
      req_new_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_sent++;
   endtask

   always @(posedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else rsp_stall <= !quiet_phase && ($urandom_range(0, 99) < 10);
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: misses, field extremes, the unused code, and a full pool.
      send_request(chm_pkg::OP_GET, 32'sh8000_0000, '0, 0);
      send_request(chm_pkg::OP_REMOVE, 32'sd5, '0, 0);
      send_request(chm_pkg::OP_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
      send_request(chm_pkg::OP_INSERT, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      send_request(chm_pkg::OP_INSERT, -32'sd1, 32'hFFFF_FFFF, 0);
      send_request(chm_pkg::OP_INSERT, 32'sd0, 32'sd0, 0);
      send_request(chm_pkg::OP_INSERT, 32'sd16, 32'sd3, 0);
      send_request(chm_pkg::OP_INSERT, 32'sh8000_0000, 32'sd9, 0);
      send_request(chm_pkg::OP_GET, 32'sh8000_0000, '0, 0);
      send_request(chm_pkg::OP_GET, -32'sd1, '0, 0);
      send_request(chm_pkg::OP_GET, 32'sd32, '0, 0);
      send_request(chm_pkg::OP_REMOVE, 32'sd0, '0, 0);
      send_request(chm_pkg::OP_GET, 32'sd16, '0, 0);
      send_request(chm_pkg::OP_UNUSED, 32'sd16, 32'sd1, 0);
      send_request(chm_pkg::OP_REMOVE, 32'sd0, '0, 0);
      for (int i = 0; i < 66; i++)
         send_request(chm_pkg::OP_INSERT, 1000 + i, $urandom(), 0);
      send_request(chm_pkg::OP_GET, 32'sd1065, '0, 0);
      for (int i = 0; i < 70; i++) send_request(chm_pkg::OP_REMOVE, 1000 + i, '0, 1);
      for (int i = 0; i < 1800; i++) begin
         logic [chm_pkg::OP_W-1:0] op;
         if (i == 600) quiet_phase = 1'b1;
         if (i == 900) quiet_phase = 1'b0;
         case ($urandom_range(0, 19))
            0: op = chm_pkg::OP_UNUSED;
            1, 2, 3, 4, 5, 6, 7: op = chm_pkg::OP_INSERT;
            8, 9, 10, 11, 12, 13: op = chm_pkg::OP_GET;
            default: op = chm_pkg::OP_REMOVE;
         endcase
         send_request(op, pick_key(), $urandom(), 1);
      end
      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (300) @(posedge clock);
      if (fail_count == 0) $display("chained_hash_map_core_tb: clean");
      else $display("chained_hash_map_core_tb: errors");
      $finish;
   end

   // Holds the response side for a long stretch while requests keep coming.
   initial begin
      wait (req_sent == 300);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #20ms;
      $display("chained_hash_map_core_tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
